>>> hw/rtl/assert_macros.svh
// assertion macros used by the checker file facs_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define FACS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define FACS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> hw/rtl/facs_pkg.sv
// shared types and constants of the arrival capture sequencer
// no dependencies
package facs_pkg;

    localparam int CHANNELS_DEF = 4;
    localparam int BYTES_PER_CH = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int APB_AW = 3;

    localparam logic [15:0] DELAY_TICKS_RST = 16'd20000;
    localparam logic [7:0] MAX_ROUNDS_RST = 8'd3;
    localparam logic [7:0] ID_BASE = 8'h41;
    localparam logic [7:0] ROUND_SAT = 8'hFF;

    typedef enum logic [2:0] {
        CMD_CAPTURE = 3'd0,
        CMD_TRIG_HI = 3'd1,
        CMD_TRIG_LO = 3'd2,
        CMD_READ_DONE = 3'd3,
        CMD_RESET = 3'd4,
        CMD_TICK = 3'd5
    } t_cmd;

    typedef enum logic {
        REG_DELAY_TICKS = 1'b0,
        REG_MAX_ROUNDS = 1'b1
    } t_reg;

    typedef struct packed {
        logic [15:0] delay_ticks;
        logic [7:0] max_rounds;
    } t_cfg;

    typedef struct packed {
        logic pkt_waiting;
        logic cap_armed;
        logic [7:0] rounds_done;
        logic delay_over;
    } t_stat;

    localparam int STAT_W = $bits(t_stat);

endpackage

>>> hw/rtl/facs_front.sv
// front end: accepts events, updates capture and delay state, queues one entry per event
// depends on facs_pkg
module facs_front #(
    parameter int CHANNELS = 4
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  facs_pkg::t_cfg                            i_cfg,
    input  logic                                      i_valid,
    output logic                                      o_ready,
    input  logic [2:0]                                i_cmd,
    input  logic [1:0]                                i_channel,
    input  logic [31:0]                               i_capture_time,
    input  logic                                      i_full,
    output logic                                      o_push,
    output logic [1+facs_pkg::STAT_W+32*CHANNELS-1:0] o_entry
);
    import facs_pkg::*;

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [CHANNELS-1:0][31:0] r_time, n_time;
    logic [CHANNELS-1:0]       r_mark, n_mark;
    logic                      r_cap, n_cap;
    logic                      r_rdy, n_rdy;
    logic [7:0]                r_rnd, n_rnd;
    logic                      r_trig, n_trig;
    logic                      r_dfin, n_dfin;
    logic                      r_dact, n_dact;
    logic [15:0]               r_dcnt, n_dcnt;
    logic                      w_acc;
    logic                      w_send;
    logic                      w_ch_ok;
    logic [CW-1:0]             w_ch;
    t_stat                     w_stat;

    assign o_ready = !i_full;
    assign w_acc = i_valid && !i_full;
    assign w_ch_ok = int'(i_channel) < CHANNELS;
    assign w_ch = CW'(i_channel);

    always_comb begin
        n_time = r_time;
        n_mark = r_mark;
        n_cap = r_cap;
        n_rdy = r_rdy;
        n_rnd = r_rnd;
        n_trig = r_trig;
        n_dfin = r_dfin;
        n_dact = r_dact;
        n_dcnt = r_dcnt;
        w_send = 1'b0;
        if (w_acc) begin
            unique case (t_cmd'(i_cmd))
                CMD_CAPTURE: begin
                    if (r_cap && w_ch_ok) begin
                        if (!r_mark[w_ch]) begin
                            n_time[w_ch] = i_capture_time;
                            n_mark[w_ch] = 1'b1;
                            if (&n_mark) begin
                                n_cap = 1'b0;
                                n_rdy = 1'b1;
                                w_send = 1'b1;
                            end
                        end
                    end
                end
                CMD_TRIG_HI: begin
                    n_trig = 1'b1;
                    if (r_rnd < i_cfg.max_rounds && !r_dfin) begin
                        n_dcnt = '0;
                        n_dact = 1'b1;
                    end
                end
                CMD_TRIG_LO: begin
                    n_trig = 1'b0;
                    if (r_cap) begin
                        n_cap = 1'b0;
                        n_mark = '0;
                        n_rdy = 1'b0;
                    end
                    if (r_dact) begin
                        n_dact = 1'b0;
                        n_dfin = 1'b0;
                    end
                end
                CMD_READ_DONE: begin
                    if (r_rdy) begin
                        n_rdy = 1'b0;
                        if (r_rnd != ROUND_SAT) begin
                            n_rnd = r_rnd + 8'd1;
                        end
                        if (n_rnd >= i_cfg.max_rounds) begin
                            n_cap = 1'b0;
                            n_dfin = 1'b0;
                        end else begin
                            n_mark = '0;
                            if (r_trig && r_dfin) begin
                                n_cap = 1'b1;
                            end
                        end
                    end
                end
                CMD_RESET: begin
                    n_rnd = '0;
                    n_dfin = 1'b0;
                    n_dact = 1'b0;
                    n_dcnt = '0;
                    n_cap = 1'b0;
                    n_mark = '0;
                    n_rdy = 1'b0;
                    if (r_trig && i_cfg.max_rounds != 8'd0) begin
                        n_dact = 1'b1;
                    end
                end
                CMD_TICK: begin
                    if (r_dact) begin
                        n_dcnt = r_dcnt + 16'd1;
                        if (n_dcnt >= i_cfg.delay_ticks) begin
                            n_dact = 1'b0;
                            n_dfin = 1'b1;
                            if (r_trig && r_rnd < i_cfg.max_rounds) begin
                                n_cap = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_stat.pkt_waiting = n_rdy;
        w_stat.cap_armed = n_cap;
        w_stat.rounds_done = n_rnd;
        w_stat.delay_over = n_dfin;
    end

    assign o_push = w_acc;
    assign o_entry = {w_send, w_stat, n_time};

    always_ff @(posedge i_clk) begin
        r_time <= n_time;
        if (!i_rst_n) begin
            r_mark <= '0;
            r_cap <= 1'b0;
            r_rdy <= 1'b0;
            r_rnd <= '0;
            r_trig <= 1'b0;
            r_dfin <= 1'b0;
            r_dact <= 1'b0;
            r_dcnt <= '0;
        end else begin
            r_mark <= n_mark;
            r_cap <= n_cap;
            r_rdy <= n_rdy;
            r_rnd <= n_rnd;
            r_trig <= n_trig;
            r_dfin <= n_dfin;
            r_dact <= n_dact;
            r_dcnt <= n_dcnt;
        end
    end

endmodule

>>> hw/rtl/facs_queue.sv
// short queue of event entries between front and back end
// depends on facs_pkg
module facs_queue #(
    parameter int W = 8,
    parameter int DEPTH = facs_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);
    import facs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [W-1:0]    r_mem [DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [CNTW-1:0] r_cnt;

    assign o_full = r_cnt == CNTW'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNTW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNTW'(1);
            end
        end
    end

endmodule

>>> hw/rtl/facs_back.sv
// back end: turns queued entries into status or packet items through an output register
// depends on facs_pkg
module facs_back #(
    parameter int CHANNELS = 4
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_empty,
    input  logic [1+facs_pkg::STAT_W+32*CHANNELS-1:0] i_entry,
    output logic                                      o_pop,
    output logic                                      o_valid,
    input  logic                                      i_ready,
    output logic                                      o_pkt_waiting,
    output logic                                      o_cap_armed,
    output logic [7:0]                                o_rounds_done,
    output logic                                      o_delay_over,
    output logic                                      o_byte_valid,
    output logic [7:0]                                o_packet_byte,
    output logic                                      o_last
);
    import facs_pkg::*;

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PW = $clog2(BYTES_PER_CH);

    logic [CHANNELS-1:0][31:0] w_times;
    t_stat                     w_stat;
    logic                      w_send;
    logic                      w_adv;
    logic                      w_last;
    logic [31:0]               w_word;
    logic [4:0]                w_shift;
    logic [7:0]                w_byte;
    logic [CW-1:0]             r_ch;
    logic [PW-1:0]             r_pos;
    logic                      r_ov;
    t_stat                     r_stat;
    logic                      r_bv;
    logic [7:0]                r_byte;
    logic                      r_last;

    assign w_times = i_entry[32*CHANNELS-1:0];
    assign w_stat = i_entry[32*CHANNELS +: STAT_W];
    assign w_send = i_entry[32*CHANNELS+STAT_W];
    assign w_adv = !r_ov || i_ready;

    assign w_word = w_times[r_ch];
    assign w_shift = 5'({r_pos - PW'(1), 3'b000});
    assign w_byte = (r_pos == '0) ? ID_BASE + 8'(r_ch) : 8'(w_word >> w_shift);
    assign w_last = !w_send
        || (r_ch == CW'(CHANNELS - 1) && r_pos == PW'(BYTES_PER_CH - 1));
    assign o_pop = w_adv && !i_empty && w_last;

    always_ff @(posedge i_clk) begin
        if (w_adv && !i_empty) begin
            r_stat <= w_stat;
            r_bv <= w_send;
            r_byte <= w_send ? w_byte : 8'd0;
            r_last <= w_last;
        end
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_ch <= '0;
            r_pos <= '0;
        end else if (w_adv) begin
            r_ov <= !i_empty;
            if (!i_empty) begin
                if (w_last) begin
                    r_ch <= '0;
                    r_pos <= '0;
                end else if (r_pos == PW'(BYTES_PER_CH - 1)) begin
                    r_ch <= r_ch + CW'(1);
                    r_pos <= '0;
                end else begin
                    r_pos <= r_pos + PW'(1);
                end
            end
        end
    end

    assign o_valid = r_ov;
    assign o_pkt_waiting = r_stat.pkt_waiting;
    assign o_cap_armed = r_stat.cap_armed;
    assign o_rounds_done = r_stat.rounds_done;
    assign o_delay_over = r_stat.delay_over;
    assign o_byte_valid = r_bv;
    assign o_packet_byte = r_byte;
    assign o_last = r_last;

endmodule

>>> hw/rtl/four_channel_arrival_capture_sequencer_top.sv
// arrival capture sequencer top: config registers, front end, queue, back end
// path: an accepted event is written into the queue, then into the output register that drives o_valid
// throughput: one event accepted per cycle while the two-entry queue has room;
// the output register gives one item per cycle while i_ready takes them: one per event, 5*CHANNELS for a full capture
// reset: synchronous active low, clears state and queue, registers back to 20000 and 3
module four_channel_arrival_capture_sequencer_top #(
    parameter int CHANNELS = facs_pkg::CHANNELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [facs_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [2:0]                  i_cmd,
    input  logic [1:0]                  i_channel,
    input  logic [31:0]                 i_capture_time,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_pkt_waiting,
    output logic                        o_cap_armed,
    output logic [7:0]                  o_rounds_done,
    output logic                        o_delay_over,
    output logic                        o_byte_valid,
    output logic [7:0]                  o_packet_byte,
    output logic                        o_last
);
    import facs_pkg::*;

    localparam int EW = 1 + STAT_W + 32 * CHANNELS;

    t_cfg          r_cfg;
    t_reg          w_reg;
    logic          w_wr;
    logic          w_push;
    logic          w_pop;
    logic          w_full;
    logic          w_empty;
    logic [EW-1:0] w_in_entry;
    logic [EW-1:0] w_out_entry;

    assign pready = 1'b1;
    assign w_reg = t_reg'(paddr[2]);
    assign w_wr = psel && penable && pwrite;

    always_comb begin
        unique case (w_reg)
            REG_DELAY_TICKS: prdata = 32'(r_cfg.delay_ticks);
            REG_MAX_ROUNDS:  prdata = 32'(r_cfg.max_rounds);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delay_ticks <= DELAY_TICKS_RST;
            r_cfg.max_rounds <= MAX_ROUNDS_RST;
        end else if (w_wr) begin
            unique case (w_reg)
                REG_DELAY_TICKS: r_cfg.delay_ticks <= pwdata[15:0];
                REG_MAX_ROUNDS:  r_cfg.max_rounds <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    facs_front #(
        .CHANNELS(CHANNELS)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg(r_cfg),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_cmd(i_cmd),
        .i_channel(i_channel),
        .i_capture_time(i_capture_time),
        .i_full(w_full),
        .o_push(w_push),
        .o_entry(w_in_entry)
    );

    facs_queue #(
        .W(EW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(w_push),
        .i_data(w_in_entry),
        .i_pop(w_pop),
        .o_data(w_out_entry),
        .o_full(w_full),
        .o_empty(w_empty)
    );

    facs_back #(
        .CHANNELS(CHANNELS)
    ) u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_empty(w_empty),
        .i_entry(w_out_entry),
        .o_pop(w_pop),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_pkt_waiting(o_pkt_waiting),
        .o_cap_armed(o_cap_armed),
        .o_rounds_done(o_rounds_done),
        .o_delay_over(o_delay_over),
        .o_byte_valid(o_byte_valid),
        .o_packet_byte(o_packet_byte),
        .o_last(o_last)
    );

endmodule

>>> hw/rtl/facs_checker.sv
// port-level checks of the arrival capture sequencer, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module facs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_ready,
    input logic       o_valid,
    input logic       o_byte_valid,
    input logic [7:0] o_packet_byte,
    input logic       o_last,
    input logic       o_pkt_waiting
);

    // a stalled item holds
    `FACS_ASSERT(a_out_hold, o_valid && !i_ready |=> o_valid && $stable(o_packet_byte), "stall lost")
    // a status item is always the last of its event
    `FACS_ASSERT(a_status_last, o_valid && !o_byte_valid |-> o_last, "status item without last")
    // packet bytes only go out with a packet pending
    `FACS_ASSERT(a_pkt_ready, o_valid && o_byte_valid |-> o_pkt_waiting, "byte without packet")
    // nothing comes out straight after reset
    `FACS_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> !o_valid, "item valid after reset")

endmodule

bind four_channel_arrival_capture_sequencer_top facs_checker u_facs_checker (.*);

>>> tb/tb_top.sv
// self-checking bench for the four-channel arrival capture sequencer top
// holds its own predictor of the capture, delay and round logic; needs facs_pkg and the top
`timescale 1ns / 100ps

module tb_top;
    import facs_pkg::*;

    localparam int NCH = CHANNELS_DEF;
    localparam int PKT_LEN = NCH * BYTES_PER_CH;
    localparam int RAND_ITEMS = 180;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int END_CYCLES = 100;
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;

    typedef struct {
        logic [2:0]  cmd;
        logic [1:0]  ch;
        logic [31:0] stamp;
    } t_evt;

    typedef struct packed {
        t_stat       stat;
        logic        byte_valid;
        logic [7:0]  packet_byte;
        logic        last;
    } t_emit;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_cmd = CMD_TICK;
    logic [1:0]  i_channel = '0;
    logic [31:0] i_capture_time = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_pkt_waiting;
    logic        o_cap_armed;
    logic [7:0]  o_rounds_done;
    logic        o_delay_over;
    logic        o_byte_valid;
    logic [7:0]  o_packet_byte;
    logic        o_last;

    four_channel_arrival_capture_sequencer_top i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_cmd             (i_cmd),
        .i_channel         (i_channel),
        .i_capture_time    (i_capture_time),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_pkt_waiting     (o_pkt_waiting),
        .o_cap_armed       (o_cap_armed),
        .o_rounds_done     (o_rounds_done),
        .o_delay_over      (o_delay_over),
        .o_byte_valid      (o_byte_valid),
        .o_packet_byte     (o_packet_byte),
        .o_last            (o_last)
    );

    // predictor state and register copies
    logic [15:0] cfg_delay;
    logic [7:0]  cfg_rounds;
    logic [31:0] held_time [NCH];
    logic [NCH-1:0] held_mark;
    logic        cap_on;
    logic        ready_flag;
    logic [7:0]  round_cnt;
    logic        trig_level;
    logic        delay_ended;
    logic        delay_run;
    logic [15:0] delay_cnt;

    t_evt  event_backlog [$];
    t_emit due_results [$];
    int    n_errors = 0;
    int    n_queued = 0;
    bit    throttle_on = 1'b0;
    int    send_gap = 0;
    int    stall_left = 0;
    int    quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!throttle_on || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_stamp();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            n_errors++;
        end
    endtask

    task automatic clear_held();
        for (int i = 0; i < NCH; i++) begin
            held_time[i] = '0;
        end
        held_mark = '0;
    endtask

    task automatic start_delay();
        trig_level = 1'b1;
        if (round_cnt < cfg_rounds && !delay_ended) begin
            delay_cnt = '0;
            delay_run = 1'b1;
        end
    endtask

    // works out the results of one accepted item and queues them
    task automatic advance_sequencer(input t_evt ev);
        bit send;
        int c;
        int p;
        t_emit r;
        send = 1'b0;
        case (ev.cmd)
            CMD_CAPTURE: begin
                if (cap_on && ev.ch < NCH && !held_mark[ev.ch]) begin
                    held_time[ev.ch] = ev.stamp;
                    held_mark[ev.ch] = 1'b1;
                    if (&held_mark) begin
                        cap_on = 1'b0;
                        ready_flag = 1'b1;
                        send = 1'b1;
                    end
                end
            end
            CMD_TRIG_HI: begin
                start_delay();
            end
            CMD_TRIG_LO: begin
                trig_level = 1'b0;
                if (cap_on) begin
                    cap_on = 1'b0;
                    clear_held();
                    ready_flag = 1'b0;
                end
                if (delay_run) begin
                    delay_run = 1'b0;
                    delay_ended = 1'b0;
                end
            end
            CMD_READ_DONE: begin
                if (ready_flag) begin
                    ready_flag = 1'b0;
                    if (round_cnt != ROUND_SAT)
                        round_cnt++;
                    if (round_cnt >= cfg_rounds) begin
                        cap_on = 1'b0;
                        delay_ended = 1'b0;
                    end else begin
                        clear_held();
                        if (trig_level && delay_ended)
                            cap_on = 1'b1;
                    end
                end
            end
            CMD_RESET: begin
                round_cnt = '0;
                delay_ended = 1'b0;
                delay_run = 1'b0;
                delay_cnt = '0;
                cap_on = 1'b0;
                clear_held();
                ready_flag = 1'b0;
                if (trig_level)
                    start_delay();
            end
            CMD_TICK: begin
                if (delay_run) begin
                    delay_cnt = delay_cnt + 16'd1;
                    if (delay_cnt >= cfg_delay) begin
                        delay_run = 1'b0;
                        delay_ended = 1'b1;
                        if (trig_level && round_cnt < cfg_rounds)
                            cap_on = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        r.stat.pkt_waiting = ready_flag;
        r.stat.cap_armed = cap_on;
        r.stat.rounds_done = round_cnt;
        r.stat.delay_over = delay_ended;
        if (!send) begin
            r.byte_valid = 1'b0;
            r.packet_byte = '0;
            r.last = 1'b1;
            due_results.push_back(r);
        end else begin
            for (int i = 0; i < PKT_LEN; i++) begin
                c = i / BYTES_PER_CH;
                p = i % BYTES_PER_CH;
                r.byte_valid = 1'b1;
                if (p == 0)
                    r.packet_byte = ID_BASE + 8'(c);
                else
                    r.packet_byte = held_time[c][8*(p-1) +: 8];
                r.last = (i == PKT_LEN - 1);
                due_results.push_back(r);
            end
        end
    endtask

    task automatic queue_event(input logic [2:0] cmd, input logic [1:0] ch,
                               input logic [31:0] stamp);
        t_evt ev;
        ev.cmd = cmd;
        ev.ch = ch;
        ev.stamp = stamp;
        event_backlog.push_back(ev);
        n_queued++;
    endtask

    // waits until every item is taken and every result has come back
    task automatic drain();
        do @(negedge i_clk);
        while (event_backlog.size() != 0 || i_valid || due_results.size() != 0);
    endtask

    task automatic write_reg(input t_reg idx, input logic [31:0] val);
        logic [31:0] want;
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_DELAY_TICKS) begin
            cfg_delay = val[15:0];
            want = {16'd0, cfg_delay};
        end else begin
            cfg_rounds = val[7:0];
            want = {24'd0, cfg_rounds};
        end
        // read back
        @(posedge i_clk);
        psel <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        check_field("prdata", want, prdata);
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // one trigger session: delay ticks then capture rounds, with some breakage
    task automatic queue_session();
        int order [NCH];
        int j;
        int tmp;
        int n_ticks;
        queue_event(CMD_TRIG_HI, 2'($urandom), pick_stamp());
        if ($urandom_range(0, 3) == 0)
            queue_event(CMD_RESET, 2'($urandom), pick_stamp());
        if (cfg_delay > 16'd8)
            n_ticks = $urandom_range(1, 4);
        else
            n_ticks = ((cfg_delay == 0) ? 1 : int'(cfg_delay)) + $urandom_range(0, 1);
        if ($urandom_range(0, 9) == 0)
            n_ticks--;
        repeat (n_ticks) queue_event(CMD_TICK, 2'($urandom), pick_stamp());
        repeat ($urandom_range(1, 4)) begin
            for (int i = 0; i < NCH; i++) begin
                order[i] = i;
            end
            for (int i = NCH - 1; i > 0; i--) begin
                j = $urandom_range(0, i);
                tmp = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            for (int k = 0; k < NCH; k++) begin
                queue_event(CMD_CAPTURE, 2'(order[k]), pick_stamp());
                if ($urandom_range(0, 9) == 0)
                    queue_event(CMD_CAPTURE, 2'(order[k]), pick_stamp());
                if ($urandom_range(0, 19) == 0)
                    queue_event(3'($urandom_range(0, 7)), 2'($urandom), pick_stamp());
            end
            if ($urandom_range(0, 11) == 0) begin
                queue_event(CMD_TRIG_LO, 2'($urandom), pick_stamp());
                return;
            end
            queue_event(CMD_READ_DONE, 2'($urandom), pick_stamp());
        end
        if ($urandom_range(0, 1) == 0)
            queue_event(CMD_TRIG_LO, 2'($urandom), pick_stamp());
    endtask

    // item driver
    always @(posedge i_clk) begin
        logic busy;
        t_evt ev;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            busy = i_valid && !o_ready;
            if (i_valid && o_ready) begin
                ev.cmd = i_cmd;
                ev.ch = i_channel;
                ev.stamp = i_capture_time;
                advance_sequencer(ev);
            end
            if (!busy) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (event_backlog.size() != 0) begin
                    ev = event_backlog.pop_front();
                    i_valid <= 1'b1;
                    i_cmd <= ev.cmd;
                    i_channel <= ev.ch;
                    i_capture_time <= ev.stamp;
                    send_gap <= pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_emit want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (due_results.size() == 0) begin
                    $error("result item with none expected");
                    n_errors++;
                end else begin
                    want = due_results.pop_front();
                    check_field("pkt_waiting", want.stat.pkt_waiting, o_pkt_waiting);
                    check_field("cap_armed", want.stat.cap_armed, o_cap_armed);
                    check_field("rounds_done", want.stat.rounds_done, o_rounds_done);
                    check_field("delay_over", want.stat.delay_over, o_delay_over);
                    check_field("byte_valid", want.byte_valid, o_byte_valid);
                    check_field("packet_byte", want.packet_byte, o_packet_byte);
                    check_field("last", want.last, o_last);
                end
            end
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left <= pick_gap();
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("four_channel_arrival_capture_sequencer_top regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int phase;
        int r;
        cfg_delay = DELAY_TICKS_RST;
        cfg_rounds = MAX_ROUNDS_RST;
        clear_held();
        cap_on = 1'b0;
        ready_flag = 1'b0;
        round_cnt = '0;
        trig_level = 1'b0;
        delay_ended = 1'b0;
        delay_run = 1'b0;
        delay_cnt = '0;
        throttle_on = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: spare codes, idle tick, capture while off, read with no data, trigger low
        queue_event(CMD_SPARE6, 2'd3, '1);
        queue_event(CMD_SPARE7, 2'd0, '0);
        queue_event(CMD_TICK, 2'd1, 32'h0);
        queue_event(CMD_CAPTURE, 2'd2, 32'hDEADBEEF);
        queue_event(CMD_READ_DONE, 2'd0, 32'h0);
        queue_event(CMD_TRIG_LO, 2'd0, 32'h0);
        drain();

        // zero delay, two rounds
        write_reg(REG_DELAY_TICKS, 32'd0);
        write_reg(REG_MAX_ROUNDS, 32'd2);
        queue_event(CMD_TRIG_HI, 2'd0, 32'h0);
        queue_event(CMD_TRIG_HI, 2'd0, 32'h0);
        queue_event(CMD_TICK, 2'd0, 32'h0);
        queue_event(CMD_TRIG_HI, 2'd0, 32'h0);
        queue_event(CMD_CAPTURE, 2'd0, 32'hFFFFFFFF);
        queue_event(CMD_CAPTURE, 2'd0, 32'h00000000);
        queue_event(CMD_CAPTURE, 2'd1, 32'h00000000);
        queue_event(CMD_CAPTURE, 2'd2, 32'h80000001);
        queue_event(CMD_CAPTURE, 2'd3, 32'h12345678);
        queue_event(CMD_READ_DONE, 2'd0, 32'h0);
        queue_event(CMD_CAPTURE, 2'd3, 32'hA5A5A5A5);
        queue_event(CMD_CAPTURE, 2'd2, 32'h5A5A5A5A);
        queue_event(CMD_CAPTURE, 2'd1, 32'h0F0F0F0F);
        queue_event(CMD_CAPTURE, 2'd0, 32'hF0F0F0F0);
        queue_event(CMD_READ_DONE, 2'd0, 32'h0);
        queue_event(CMD_TRIG_HI, 2'd0, 32'h0);
        queue_event(CMD_RESET, 2'd0, 32'h0);
        queue_event(CMD_TICK, 2'd0, 32'h0);
        queue_event(CMD_CAPTURE, 2'd1, 32'h00C0FFEE);
        queue_event(CMD_TRIG_LO, 2'd0, 32'h0);
        drain();

        // no rounds allowed, then longest delay and most rounds
        write_reg(REG_MAX_ROUNDS, 32'd0);
        queue_event(CMD_TRIG_HI, 2'd0, 32'h0);
        queue_event(CMD_TICK, 2'd0, 32'h0);
        drain();
        write_reg(REG_DELAY_TICKS, 32'd65535);
        write_reg(REG_MAX_ROUNDS, 32'd255);
        queue_event(CMD_TRIG_HI, 2'd0, 32'h0);
        queue_event(CMD_TICK, 2'd0, 32'h0);
        queue_event(CMD_TRIG_LO, 2'd0, 32'h0);
        drain();

        n_queued = 0;
        phase = 0;
        while (n_queued < RAND_ITEMS) begin
            throttle_on = (phase % 3 != 2);
            r = $urandom_range(0, 9);
            write_reg(REG_DELAY_TICKS,
                      (r == 0) ? 32'd0 : (r == 1) ? 32'd65535 : 32'($urandom_range(1, 6)));
            r = $urandom_range(0, 9);
            write_reg(REG_MAX_ROUNDS,
                      (r == 0) ? 32'd0 : (r == 1) ? 32'd255 : 32'($urandom_range(1, 4)));
            repeat ($urandom_range(2, 3)) queue_session();
            drain();
            phase++;
        end

        repeat (END_CYCLES) @(posedge i_clk);
        if (n_errors == 0)
            $display("four_channel_arrival_capture_sequencer_top regression: pass");
        else
            $display("four_channel_arrival_capture_sequencer_top regression: fail");
        $finish;
    end

endmodule
